// ===== rtl/crop_flip_rgb_to_bgr24_packer_assert.svh =====
// Assertion helpers for the checker file.
`ifndef CROP_FLIP_RGB_TO_BGR24_PACKER_ASSERT_SVH
`define CROP_FLIP_RGB_TO_BGR24_PACKER_ASSERT_SVH

// Clocked check, disabled while reset is active.
`define CFP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Clocked check that holds through reset as well.
`define CFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    localparam int DIM_W  = 13;
    localparam int POS_W  = 12;
    localparam int ROWB_W = 15;
    localparam int OFFS_W = 26;

    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [2:0] REG_WINDOW_TOP    = 3'd3;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd4;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd5;
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd6;
    localparam logic [2:0] REG_ORIGINAL_SIZE = 3'd7;

    localparam logic FMT_RGB565 = 1'b1;

    // floor(c*255/31) and floor(c*255/63) as c * K >> 20, exact over the input range
    localparam logic [23:0] EXP5_MUL = 24'd8625630;
    localparam logic [22:0] EXP6_MUL = 23'd4244475;

    typedef struct packed {
        logic              ok;
        logic              fmt;
        logic [POS_W-1:0]  x0;
        logic [POS_W-1:0]  y0;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [ROWB_W-1:0] rowbytes;
    } win_t;

    typedef struct packed {
        logic [POS_W-1:0] dx;
        logic [DIM_W-1:0] dy;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
    } pix_t;

    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [28:0] p;
        p = 29'(c) * 29'(EXP5_MUL);
        return p[27:20];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [28:0] p;
        p = 29'(c) * 29'(EXP6_MUL);
        return p[27:20];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_cfg
    import cfp_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output win_t        win,
    output logic        settle
);

    logic [DIM_W-1:0] src_w_reg, src_h_reg, win_w_reg, win_h_reg;
    logic [POS_W-1:0] left_reg, top_reg;
    logic             fmt_reg, orig_reg;
    logic             settle_reg;
    win_t             win_reg, win_next;
    logic             wr;
    logic [2:0]       idx;

    logic [DIM_W-1:0]  sw, sh, ww, wh, w_req, h_req, rem_w, rem_h, w_cl, h_cl;
    logic [POS_W-1:0]  x0, y0;
    logic [ROWB_W-1:0] rb_sum;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (32'(v) > 32'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : v;
    endfunction

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg  <= DIM_W'(720);
            src_h_reg  <= DIM_W'(568);
            left_reg   <= '0;
            top_reg    <= '0;
            win_w_reg  <= '0;
            win_h_reg  <= '0;
            fmt_reg    <= 1'b0;
            orig_reg   <= 1'b0;
            settle_reg <= 1'b1;
        end else begin
            settle_reg <= wr;
            if (wr) begin
                unique case (idx)
                    REG_SOURCE_WIDTH:  src_w_reg <= pwdata[DIM_W-1:0];
                    REG_SOURCE_HEIGHT: src_h_reg <= pwdata[DIM_W-1:0];
                    REG_WINDOW_LEFT:   left_reg  <= pwdata[POS_W-1:0];
                    REG_WINDOW_TOP:    top_reg   <= pwdata[POS_W-1:0];
                    REG_WINDOW_WIDTH:  win_w_reg <= pwdata[DIM_W-1:0];
                    REG_WINDOW_HEIGHT: win_h_reg <= pwdata[DIM_W-1:0];
                    REG_PIXEL_FORMAT:  fmt_reg   <= pwdata[0];
                    REG_ORIGINAL_SIZE: orig_reg  <= pwdata[0];
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            REG_SOURCE_WIDTH:  prdata = 32'(src_w_reg);
            REG_SOURCE_HEIGHT: prdata = 32'(src_h_reg);
            REG_WINDOW_LEFT:   prdata = 32'(left_reg);
            REG_WINDOW_TOP:    prdata = 32'(top_reg);
            REG_WINDOW_WIDTH:  prdata = 32'(win_w_reg);
            REG_WINDOW_HEIGHT: prdata = 32'(win_h_reg);
            REG_PIXEL_FORMAT:  prdata = 32'(fmt_reg);
            REG_ORIGINAL_SIZE: prdata = 32'(orig_reg);
        endcase
    end

    // window geometry, registered; input is held off in the cycle after a write
    always_comb begin
        sw    = sat_dim(src_w_reg);
        sh    = sat_dim(src_h_reg);
        ww    = sat_dim(win_w_reg);
        wh    = sat_dim(win_h_reg);
        x0    = orig_reg ? '0 : left_reg;
        y0    = orig_reg ? '0 : top_reg;
        w_req = (orig_reg || ww == '0) ? sw : ww;
        h_req = (orig_reg || wh == '0) ? sh : wh;
        rem_w = sw - {1'b0, x0};
        rem_h = sh - {1'b0, y0};
        w_cl  = (w_req > rem_w) ? rem_w : w_req;
        h_cl  = (h_req > rem_h) ? rem_h : h_req;
        rb_sum = {2'b00, w_cl} + {1'b0, w_cl, 1'b0} + ROWB_W'(3);

        win_next.ok       = (sw != '0) && (sh != '0) && ({1'b0, x0} < sw) &&
                            ({1'b0, y0} < sh) && (w_cl != '0) && (h_cl != '0);
        win_next.fmt      = fmt_reg;
        win_next.x0       = x0;
        win_next.y0       = y0;
        win_next.w        = w_cl;
        win_next.h        = h_cl;
        win_next.rowbytes = {rb_sum[ROWB_W-1:2], 2'b00};
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign win    = win_reg;
    assign settle = settle_reg;

endmodule

`default_nettype wire

// ===== rtl/cfp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_front
    import cfp_pkg::*;
(
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  [31:0]       s_pixel_word,
    input  wire  [POS_W-1:0]  s_column,
    input  wire  [POS_W-1:0]  s_line,
    input  wire win_t         win,
    input  wire               settle,
    input  wire               q_full,
    output logic              push,
    output pix_t              push_data
);

    logic [POS_W-1:0] dx, ly;
    logic             keep;

    always_comb begin
        dx   = s_column - win.x0;
        ly   = s_line - win.y0;
        keep = win.ok && (s_column >= win.x0) && ({1'b0, dx} < win.w) &&
               (s_line >= win.y0) && ({1'b0, ly} < win.h);

        push_data.dx = dx;
        push_data.dy = win.h - DIM_W'(1) - {1'b0, ly};
        if (win.fmt == FMT_RGB565) begin
            push_data.red   = expand5(s_pixel_word[15:11]);
            push_data.green = expand6(s_pixel_word[10:5]);
            push_data.blue  = expand5(s_pixel_word[4:0]);
        end else begin
            push_data.red   = s_pixel_word[23:16];
            push_data.green = s_pixel_word[15:8];
            push_data.blue  = s_pixel_word[7:0];
        end
    end

    // out-of-window beats are taken and dropped
    assign s_ready = !q_full && !settle;
    assign push    = s_valid && s_ready && keep;

endmodule

`default_nettype wire

// ===== rtl/cfp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_queue
    import cfp_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        push,
    input  wire pix_t  push_data,
    input  wire        pop,
    output logic       full,
    output logic       not_empty,
    output pix_t       head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/cfp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_back
    import cfp_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               q_valid,
    input  wire pix_t         head,
    output logic              pop,
    input  wire win_t         win,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [OFFS_W-1:0] m_byte_offset,
    output logic [7:0]        m_blue,
    output logic [7:0]        m_green,
    output logic [7:0]        m_red,
    output logic [DIM_W-1:0]  m_active_width,
    output logic [DIM_W-1:0]  m_active_height
);

    logic              s1_valid_reg, s2_valid_reg;
    logic [OFFS_W-1:0] s1_prod_reg;
    logic [13:0]       s1_dx3_reg;
    logic [7:0]        s1_blue_reg, s1_green_reg, s1_red_reg;
    logic [OFFS_W-1:0] offset_reg;
    logic [7:0]        blue_reg, green_reg, red_reg;
    logic              s2_ready, s1_ready;
    logic [27:0]       prod;

    assign s2_ready = !s2_valid_reg || m_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = q_valid && s1_ready;
    assign prod     = 28'(head.dy) * 28'(win.rowbytes);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_prod_reg  <= prod[OFFS_W-1:0];
            s1_dx3_reg   <= {2'b00, head.dx} + {1'b0, head.dx, 1'b0};
            s1_blue_reg  <= head.blue;
            s1_green_reg <= head.green;
            s1_red_reg   <= head.red;
        end
        if (s2_ready && s1_valid_reg) begin
            offset_reg <= s1_prod_reg + OFFS_W'(s1_dx3_reg);
            blue_reg   <= s1_blue_reg;
            green_reg  <= s1_green_reg;
            red_reg    <= s1_red_reg;
        end
    end

    assign m_valid         = s2_valid_reg;
    assign m_byte_offset   = offset_reg;
    assign m_blue          = blue_reg;
    assign m_green         = green_reg;
    assign m_red           = red_reg;
    assign m_active_width  = win.w;
    assign m_active_height = win.h;

endmodule

`default_nettype wire

// ===== rtl/crop_flip_rgb_to_bgr24_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Crops a pixel stream to a window, flips it bottom-up and packs it as 24-bit
// BGR with rows padded to 4 bytes. One beat is taken per clock, sustained,
// unless a result stall fills the queue or a register write settles; each
// beat is one pixel with its column and line, as xRGB or RGB565 per the
// format register. A pixel in the window passes the queue entry (written as
// it is taken), the multiply stage and the add/output stage to one result
// beat: blue byte offset, BGR bytes and effective window size. Pixels outside
// the window, or an empty window, are taken and give no result. The dy*rowbytes
// multiply has a stage of its own. The queue full flag is from a registered
// count, so input resumes in the cycle after a full queue drains an entry.
// Input is held off in the cycle after reset and after each register write
// while the geometry is recomputed. Registers sit at byte address 4*index;
// the user must write them only while the block is idle; nothing enforces it.
module crop_flip_rgb_to_bgr24_packer
    import cfp_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [4:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  [31:0]       s_pixel_word,
    input  wire  [POS_W-1:0]  s_column,
    input  wire  [POS_W-1:0]  s_line,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [OFFS_W-1:0] m_byte_offset,
    output logic [7:0]        m_blue,
    output logic [7:0]        m_green,
    output logic [7:0]        m_red,
    output logic [DIM_W-1:0]  m_active_width,
    output logic [DIM_W-1:0]  m_active_height
);

    win_t win;
    logic settle, q_full, q_valid, push, pop;
    pix_t push_data, head;

    cfp_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .win     (win),
        .settle  (settle)
    );

    cfp_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_word (s_pixel_word),
        .s_column     (s_column),
        .s_line       (s_line),
        .win          (win),
        .settle       (settle),
        .q_full       (q_full),
        .push         (push),
        .push_data    (push_data)
    );

    cfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    cfp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .head            (head),
        .pop             (pop),
        .win             (win),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_offset   (m_byte_offset),
        .m_blue          (m_blue),
        .m_green         (m_green),
        .m_red           (m_red),
        .m_active_width  (m_active_width),
        .m_active_height (m_active_height)
    );

endmodule

`default_nettype wire

// ===== rtl/cfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "crop_flip_rgb_to_bgr24_packer_assert.svh"

module cfp_checker #(
    parameter int MAX_DIMENSION = 4096
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        psel,
    input wire        penable,
    input wire        pwrite,
    input wire        pready,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [25:0] m_byte_offset,
    input wire [7:0]  m_blue,
    input wire [7:0]  m_green,
    input wire [7:0]  m_red,
    input wire [12:0] m_active_width,
    input wire [12:0] m_active_height
);

    `CFP_ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready dropped")

    `CFP_ASSERT_RST(a_write_holds_input, aclk, aresetn,
        (psel && penable && pwrite) |=> !s_ready, "input taken right after a write")

    `CFP_ASSERT_RST(a_size_in_range, aclk, aresetn,
        m_valid |-> (m_active_width != 13'd0 && m_active_height != 13'd0 &&
            32'(m_active_width) <= 32'(MAX_DIMENSION) &&
            32'(m_active_height) <= 32'(MAX_DIMENSION)),
        "result window size out of range")

    `CFP_ASSERT_RST(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_byte_offset) &&
            $stable(m_blue) && $stable(m_green) && $stable(m_red)),
        "stalled result beat changed")

endmodule

bind crop_flip_rgb_to_bgr24_packer cfp_checker #(
    .MAX_DIMENSION(MAX_DIMENSION)
) u_cfp_checker (.*);

`default_nettype wire
